// ===== hw/rtl/avi_ifb_pkg.sv =====
// Shared types and constants for the AVI infoframe builder.
`timescale 1ns / 1ps

package avi_ifb_pkg;

    localparam int unsigned CLK_IN_W  = 20;
    localparam int unsigned CLK_EFF_W = 21;
    localparam int unsigned DIM_W     = 16;
    localparam int unsigned CFG_W     = 2;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_CONV_ON           = 2'd0,
        REG_TX_PIXEL_ENCODING = 2'd1,
        REG_TX_FULL_RANGE     = 2'd2
    } t_reg_idx;

    // pixel encodings
    localparam logic [2:0] ENC_RGB      = 3'd0;
    localparam logic [2:0] ENC_YCC422   = 3'd1;
    localparam logic [2:0] ENC_YCC444   = 3'd2;
    localparam logic [2:0] ENC_YCC420   = 3'd3;
    localparam logic [2:0] ENC_RGB_WIDE = 3'd4;

    localparam logic [1:0] TX_ENC_RGB    = 2'd0;
    localparam logic [1:0] TX_ENC_YCC420 = 2'd3;

    localparam logic [1:0] DEPTH_OTHER = 2'd3;

    // colorimetry codes
    localparam logic [3:0] COL_BT601       = 4'd1;
    localparam logic [3:0] COL_BT709       = 4'd2;
    localparam logic [3:0] COL_XV601       = 4'd3;
    localparam logic [3:0] COL_XV709       = 4'd4;
    localparam logic [3:0] COL_S601        = 4'd5;
    localparam logic [3:0] COL_OP601       = 4'd6;
    localparam logic [3:0] COL_2020_CYCC   = 4'd7;
    localparam logic [3:0] COL_2020_YCC    = 4'd8;
    localparam logic [3:0] COL_2020_RGB    = 4'd9;
    localparam logic [3:0] COL_DCI_P3      = 4'd10;
    localparam logic [3:0] COL_MISC_XV601  = 4'd11;
    localparam logic [3:0] COL_MISC_BT601  = 4'd12;
    localparam logic [3:0] COL_MISC_XV709  = 4'd13;
    localparam logic [3:0] COL_MISC_BT709  = 4'd14;
    localparam logic [3:0] COL_MISC_DCI_P3 = 4'd15;

    // infoframe field values
    localparam logic [7:0] B0_A0        = 8'h10;
    localparam logic [7:0] C_601        = 8'h40;
    localparam logic [7:0] C_709        = 8'h80;
    localparam logic [7:0] C_EXT        = 8'hC0;
    localparam logic [7:0] EC_XV709     = 8'h10;
    localparam logic [7:0] EC_S601      = 8'h20;
    localparam logic [7:0] EC_OP601     = 8'h30;
    localparam logic [7:0] EC_2020_CYCC = 8'h50;
    localparam logic [7:0] EC_2020      = 8'h60;
    localparam logic [7:0] EC_P3        = 8'h70;
    localparam logic [7:0] Q_FULL       = 8'h08;
    localparam logic [7:0] Q_LIMITED    = 8'h04;
    localparam logic [7:0] Q_MASK_N     = 8'hF3;
    localparam logic [7:0] YQ_FULL      = 8'h40;
    localparam logic [7:0] ASP_16_9     = 8'h28;
    localparam logic [7:0] ASP_14_9     = 8'h0B;
    localparam logic [7:0] ASP_4_3      = 8'h19;
    localparam logic [7:0] ASP_NONE     = 8'h08;

    // pixel clock windows (kHz, exclusive bounds)
    localparam logic [CLK_EFF_W-1:0] W594_LO = 21'h0900B0;
    localparam logic [CLK_EFF_W-1:0] W594_HI = 21'h0927C0;
    localparam logic [CLK_EFF_W-1:0] W533_LO = 21'h081650;
    localparam logic [CLK_EFF_W-1:0] W533_HI = 21'h0829D0;
    localparam logic [CLK_EFF_W-1:0] W297_LO = 21'h046CD0;
    localparam logic [CLK_EFF_W-1:0] W297_HI = 21'h0493E0;
    localparam logic [CLK_EFF_W-1:0] W266_LO = 21'h03F7A0;
    localparam logic [CLK_EFF_W-1:0] W266_HI = 21'h041EB0;
    localparam logic [CLK_EFF_W-1:0] W148_LO = 21'h0222E0;
    localparam logic [CLK_EFF_W-1:0] W148_HI = 21'h0249F0;
    localparam logic [CLK_EFF_W-1:0] W74_LO  = 21'h011170;
    localparam logic [CLK_EFF_W-1:0] W74_HI  = 21'h0128E0;
    localparam logic [CLK_EFF_W-1:0] W27_LO  = 21'h005DC0;
    localparam logic [CLK_EFF_W-1:0] W27_HI  = 21'h006D60;

    // horizontal sizes
    localparam logic [DIM_W-1:0] H_5500 = 16'h157C;
    localparam logic [DIM_W-1:0] H_5280 = 16'h14A0;
    localparam logic [DIM_W-1:0] H_4400 = 16'h1130;
    localparam logic [DIM_W-1:0] H_4096 = 16'h1000;
    localparam logic [DIM_W-1:0] H_4000 = 16'h0FA0;
    localparam logic [DIM_W-1:0] H_3840 = 16'h0F00;
    localparam logic [DIM_W-1:0] H_2200 = 16'h0898;
    localparam logic [DIM_W-1:0] H_1920 = 16'h0780;
    localparam logic [DIM_W-1:0] H_1650 = 16'h0672;
    localparam logic [DIM_W-1:0] H_1280 = 16'h0500;
    localparam logic [DIM_W-1:0] H_858  = 16'h035A;
    localparam logic [DIM_W-1:0] H_800  = 16'h0320;
    localparam logic [DIM_W-1:0] H_720  = 16'h02D0;
    localparam logic [DIM_W-1:0] H_640  = 16'h0280;

    // CEA and HDMI VICs
    localparam logic [7:0] VIC_1   = 8'd1;
    localparam logic [7:0] VIC_2   = 8'd2;
    localparam logic [7:0] VIC_4   = 8'd4;
    localparam logic [7:0] VIC_16  = 8'd16;
    localparam logic [7:0] VIC_95  = 8'd95;
    localparam logic [7:0] VIC_96  = 8'd96;
    localparam logic [7:0] VIC_97  = 8'd97;
    localparam logic [7:0] VIC_99  = 8'd99;
    localparam logic [7:0] VIC_100 = 8'd100;
    localparam logic [7:0] VIC_101 = 8'd101;
    localparam logic [7:0] VIC_102 = 8'd102;
    localparam logic [2:0] HVIC_NONE     = 3'd0;
    localparam logic [2:0] HVIC_4K30     = 3'd1;
    localparam logic [2:0] HVIC_4K25     = 3'd2;
    localparam logic [2:0] HVIC_4K24     = 3'd3;
    localparam logic [2:0] HVIC_4096_24  = 3'd4;

    typedef struct packed {
        logic       conv_on;
        logic [1:0] tx_pixel_encoding;
        logic       tx_full_range;
    } t_cfg;

    typedef struct packed {
        logic [2:0]          pixel_encoding;
        logic [3:0]          colorimetry;
        logic                vsc_present;
        logic                src_full_range;
        logic [1:0]          src_bit_depth;
        logic [CLK_IN_W-1:0] pixel_clock_khz;
        logic [DIM_W-1:0]    h_total;
        logic [DIM_W-1:0]    h_active;
        logic [DIM_W-1:0]    v_active;
    } t_mode;

    typedef struct packed {
        logic [7:0]           avi_byte0;
        logic [7:0]           avi_byte1;
        logic [7:0]           avi_byte2;
        logic [7:0]           avi_byte3;
        logic [7:0]           avi_byte4;
        logic [2:0]           hdmi_vic;
        logic [1:0]           tx_bit_depth;
        logic [CLK_EFF_W-1:0] effective_clock_khz;
    } t_result;

endpackage

// ===== hw/rtl/avi_ifb_vic.sv =====
// Video identification code lookup from pixel clock window and horizontal timing.
`timescale 1ns / 1ps

module avi_ifb_vic (
    input  logic [avi_ifb_pkg::CLK_EFF_W-1:0] i_clk_khz,
    input  logic [avi_ifb_pkg::DIM_W-1:0]     i_h_total,
    input  logic [avi_ifb_pkg::DIM_W-1:0]     i_h_active,
    output logic [7:0]                        o_vic,
    output logic [2:0]                        o_hdmi_vic
);
    import avi_ifb_pkg::*;

    logic m4400_3840, m4400_4096, m5280_3840, m5280_4096;
    logic m5500_3840, m5500_4096, m4000_3840;

    assign m4400_3840 = (i_h_total == H_4400) && (i_h_active == H_3840);
    assign m4400_4096 = (i_h_total == H_4400) && (i_h_active == H_4096);
    assign m5280_3840 = (i_h_total == H_5280) && (i_h_active == H_3840);
    assign m5280_4096 = (i_h_total == H_5280) && (i_h_active == H_4096);
    assign m5500_3840 = (i_h_total == H_5500) && (i_h_active == H_3840);
    assign m5500_4096 = (i_h_total == H_5500) && (i_h_active == H_4096);
    assign m4000_3840 = (i_h_total == H_4000) && (i_h_active == H_3840);

    always_comb begin
        o_vic      = 8'd0;
        o_hdmi_vic = HVIC_NONE;
        priority if (i_clk_khz > W594_LO && i_clk_khz < W594_HI) begin
            priority if (m4400_3840) o_vic = VIC_97;
            else if (m4400_4096)     o_vic = VIC_102;
            else if (m5280_3840)     o_vic = VIC_96;
            else if (m5280_4096)     o_vic = VIC_101;
            else                     o_vic = 8'd0;
        end else if (i_clk_khz > W533_LO && i_clk_khz < W533_HI) begin
            if (m4000_3840) o_vic = VIC_97;
        end else if (i_clk_khz > W297_LO && i_clk_khz < W297_HI) begin
            priority if (m5500_3840) o_hdmi_vic = HVIC_4K24;
            else if (m5280_3840)     o_hdmi_vic = HVIC_4K25;
            else if (m4400_3840)     o_hdmi_vic = HVIC_4K30;
            else if (m5500_4096)     o_hdmi_vic = HVIC_4096_24;
            else if (m5280_4096)     o_vic = VIC_99;
            else if (m4400_4096)     o_vic = VIC_100;
            else                     o_vic = 8'd0;
        end else if (i_clk_khz > W266_LO && i_clk_khz < W266_HI) begin
            if (m4000_3840) o_vic = VIC_95;
        end else if (i_clk_khz > W148_LO && i_clk_khz < W148_HI) begin
            if (i_h_total == H_2200 && i_h_active == H_1920) o_vic = VIC_16;
        end else if (i_clk_khz > W74_LO && i_clk_khz < W74_HI) begin
            if (i_h_total == H_1650 && i_h_active == H_1280) o_vic = VIC_4;
        end else if (i_clk_khz > W27_LO && i_clk_khz < W27_HI) begin
            priority if (i_h_total == H_858 && i_h_active == H_720)      o_vic = VIC_2;
            else if (i_h_total == H_800 && i_h_active == H_640)          o_vic = VIC_1;
            else                                                         o_vic = 8'd0;
        end else begin
            o_vic = 8'd0;
        end
    end

endmodule

// ===== hw/rtl/avi_ifb_map.sv =====
// Mode to infoframe mapping: colour fields, aspect, VIC and conversion override.
`timescale 1ns / 1ps

module avi_ifb_map (
    input  avi_ifb_pkg::t_cfg    i_cfg,
    input  avi_ifb_pkg::t_mode   i_mode,
    output avi_ifb_pkg::t_result o_res
);
    import avi_ifb_pkg::*;

    logic [CLK_EFF_W-1:0] eff_clk;
    logic [7:0]           vic;
    logic [2:0]           hvic;
    logic [20:0]          ha9, ha3, va16, va14, va4;
    logic [7:0]           b0, b1, b2, b4;
    logic [2:0]           enc;
    logic [3:0]           col;
    logic                 full;

    assign enc  = i_mode.pixel_encoding;
    assign col  = i_mode.colorimetry;
    assign full = i_mode.src_full_range;

    // 4:2:0 sources that stay 4:2:0 on the link run at half the pixel rate
    assign eff_clk = (enc == ENC_YCC420 &&
                      (!i_cfg.conv_on || i_cfg.tx_pixel_encoding == TX_ENC_YCC420))
                   ? {i_mode.pixel_clock_khz, 1'b0}
                   : {1'b0, i_mode.pixel_clock_khz};

    assign ha9  = 21'(i_mode.h_active) * 21'd9;
    assign ha3  = 21'(i_mode.h_active) * 21'd3;
    assign va16 = 21'(i_mode.v_active) * 21'd16;
    assign va14 = 21'(i_mode.v_active) * 21'd14;
    assign va4  = 21'(i_mode.v_active) * 21'd4;

    avi_ifb_vic u_vic (
        .i_clk_khz  (eff_clk),
        .i_h_total  (i_mode.h_total),
        .i_h_active (i_mode.h_active),
        .o_vic      (vic),
        .o_hdmi_vic (hvic)
    );

    always_comb begin
        b1 = 8'd0;
        b2 = 8'd0;
        b4 = 8'd0;

        unique case (enc)
            ENC_YCC422: b0 = B0_A0 | 8'h20;
            ENC_YCC444: b0 = B0_A0 | 8'h40;
            ENC_YCC420: b0 = B0_A0 | 8'h60;
            default:    b0 = B0_A0;
        endcase

        if (i_mode.vsc_present) begin
            if (enc == ENC_RGB) begin
                if (col == COL_2020_RGB) begin
                    b1 = C_EXT;
                    b2 = EC_2020;
                end else if (col == COL_DCI_P3) begin
                    b1 = C_EXT;
                    b2 = EC_P3;
                end
                b2 = b2 | (full ? Q_FULL : Q_LIMITED);
            end else begin
                unique case (col)
                    COL_BT601:     b1 = C_601;
                    COL_BT709:     b1 = C_709;
                    COL_XV601:     b1 = C_EXT;
                    COL_XV709:     begin b1 = C_EXT; b2 = EC_XV709;     end
                    COL_S601:      begin b1 = C_EXT; b2 = EC_S601;      end
                    COL_OP601:     begin b1 = C_EXT; b2 = EC_OP601;     end
                    COL_2020_CYCC: begin b1 = C_EXT; b2 = EC_2020_CYCC; end
                    COL_2020_YCC:  begin b1 = C_EXT; b2 = EC_2020;      end
                    default:       b1 = 8'd0;
                endcase
                b4 = full ? YQ_FULL : 8'd0;
            end
        end else begin
            priority if (enc == ENC_RGB) begin
                b2 = full ? Q_FULL : Q_LIMITED;
            end else if (enc == ENC_YCC422 || enc == ENC_YCC444) begin
                unique case (col)
                    COL_MISC_XV601: b1 = C_EXT;
                    COL_MISC_BT601: b1 = C_601;
                    COL_MISC_XV709: begin b1 = C_EXT; b2 = EC_XV709; end
                    COL_MISC_BT709: b1 = C_709;
                    default:        b1 = 8'd0;
                endcase
            end else if (enc == ENC_RGB_WIDE) begin
                if (col == COL_MISC_DCI_P3) begin
                    b1 = C_EXT;
                    b2 = EC_P3;
                end
            end else begin
                b1 = 8'd0;
            end
        end

        priority if (ha9 == va16) b1 = b1 | ASP_16_9;
        else if (ha9 == va14)     b1 = b1 | ASP_14_9;
        else if (ha3 == va4)      b1 = b1 | ASP_4_3;
        else                      b1 = b1 | ASP_NONE;

        if (i_cfg.conv_on) begin
            b0 = B0_A0 | {1'b0, i_cfg.tx_pixel_encoding, 5'd0};
            b2 = b2 & Q_MASK_N;
            if (i_cfg.tx_pixel_encoding == TX_ENC_RGB) begin
                b2 = b2 | (i_cfg.tx_full_range ? Q_FULL : Q_LIMITED);
                b4 = 8'd0;
            end else begin
                b4 = full ? YQ_FULL : 8'd0;
            end
        end

        o_res.avi_byte0           = b0;
        o_res.avi_byte1           = b1;
        o_res.avi_byte2           = b2;
        o_res.avi_byte3           = vic;
        o_res.avi_byte4           = b4;
        o_res.hdmi_vic            = hvic;
        o_res.tx_bit_depth        = (i_mode.src_bit_depth == DEPTH_OTHER)
                                  ? 2'd0 : i_mode.src_bit_depth;
        o_res.effective_clock_khz = eff_clk;
    end

endmodule

// ===== hw/rtl/avi_infoframe_builder_core.sv =====
// Top level of the AVI infoframe builder: config registers and two-stage pipeline.
//
// Usage:
//   Input channel (i_valid / o_ready) takes one video mode word: encoding,
//   colorimetry, VSC flag, source range, bit depth, pixel clock and timing.
//   Output channel (o_valid / i_ready) returns one result word per mode:
//   AVI data bytes 1..5, HDMI VIC, deep-colour code and effective clock.
//   Config port (i_cfg_we / i_cfg_addr / i_cfg_wdata) writes the conversion
//   registers; write them only while no word is in flight.
// Timing:
//   A word accepted from the input channel lands in the input register, is mapped by
//   one pass of logic and lands in the result register once the output stage is free,
//   which raises o_valid. One word per cycle sustained while i_ready stays high;
//   the figure is set by the single mapping pass between the two registers.
// Reset:
//   Synchronous, active low. Both pipeline stages are emptied and the
//   registers return to conversion on, RGB output, full range.
// Stall:
//   When i_ready is low the result holds; the input register still fills,
//   then o_ready drops until the result is taken.
`timescale 1ns / 1ps

module avi_infoframe_builder_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_addr,
    input  logic [avi_ifb_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [2:0]                         i_pixel_encoding,
    input  logic [3:0]                         i_colorimetry,
    input  logic                               i_vsc_present,
    input  logic                               i_src_full_range,
    input  logic [1:0]                         i_src_bit_depth,
    input  logic [avi_ifb_pkg::CLK_IN_W-1:0]   i_pixel_clock_khz,
    input  logic [avi_ifb_pkg::DIM_W-1:0]      i_h_total,
    input  logic [avi_ifb_pkg::DIM_W-1:0]      i_h_active,
    input  logic [avi_ifb_pkg::DIM_W-1:0]      i_v_active,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [7:0]                         o_avi_byte0,
    output logic [7:0]                         o_avi_byte1,
    output logic [7:0]                         o_avi_byte2,
    output logic [7:0]                         o_avi_byte3,
    output logic [7:0]                         o_avi_byte4,
    output logic [2:0]                         o_hdmi_vic,
    output logic [1:0]                         o_tx_bit_depth,
    output logic [avi_ifb_pkg::CLK_EFF_W-1:0]  o_effective_clock_khz
);
    import avi_ifb_pkg::*;

    t_cfg    r_cfg;
    t_mode   r_mode;
    t_result r_res;
    t_result n_res;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    s2_ready;

    assign s2_ready = !r_out_valid || i_ready;
    assign o_ready  = !r_in_valid || s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.conv_on           <= 1'b1;
            r_cfg.tx_pixel_encoding <= TX_ENC_RGB;
            r_cfg.tx_full_range     <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_CONV_ON:           r_cfg.conv_on           <= i_cfg_wdata[0];
                REG_TX_PIXEL_ENCODING: r_cfg.tx_pixel_encoding <= i_cfg_wdata[1:0];
                REG_TX_FULL_RANGE:     r_cfg.tx_full_range     <= i_cfg_wdata[0];
                default:               r_cfg                   <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mode.pixel_encoding  <= i_pixel_encoding;
            r_mode.colorimetry     <= i_colorimetry;
            r_mode.vsc_present     <= i_vsc_present;
            r_mode.src_full_range  <= i_src_full_range;
            r_mode.src_bit_depth   <= i_src_bit_depth;
            r_mode.pixel_clock_khz <= i_pixel_clock_khz;
            r_mode.h_total         <= i_h_total;
            r_mode.h_active        <= i_h_active;
            r_mode.v_active        <= i_v_active;
        end
        if (r_in_valid && s2_ready) begin
            r_res <= n_res;
        end
    end

    avi_ifb_map u_map (
        .i_cfg  (r_cfg),
        .i_mode (r_mode),
        .o_res  (n_res)
    );

    assign o_valid               = r_out_valid;
    assign o_avi_byte0           = r_res.avi_byte0;
    assign o_avi_byte1           = r_res.avi_byte1;
    assign o_avi_byte2           = r_res.avi_byte2;
    assign o_avi_byte3           = r_res.avi_byte3;
    assign o_avi_byte4           = r_res.avi_byte4;
    assign o_hdmi_vic            = r_res.hdmi_vic;
    assign o_tx_bit_depth        = r_res.tx_bit_depth;
    assign o_effective_clock_khz = r_res.effective_clock_khz;

endmodule

// ===== hw/rtl/avi_ifb_checker.sv =====
// Port-level checks for the AVI infoframe builder, bound to the top level.
`timescale 1ns / 1ps

module avi_ifb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_avi_byte0,
    input logic [7:0] o_avi_byte3,
    input logic [2:0] o_hdmi_vic,
    input logic [1:0] o_tx_bit_depth
);

    // stalled result word stays valid; bytes 0 and 3 and HDMI VIC hold
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_avi_byte0)
                                   && $stable(o_avi_byte3) && $stable(o_hdmi_vic)))
        else $error("result word changed while stalled");

    // pipeline empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_a0_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_avi_byte0[4])
        else $error("A0 bit clear");

    // HDMI VIC and CEA VIC never both set; with an HDMI VIC the depth code is never the other value
    a_vic_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hdmi_vic != 3'd0) |-> (o_avi_byte3 == 8'd0 && o_tx_bit_depth != 2'd3))
        else $error("HDMI VIC with CEA VIC or bad depth");

endmodule

bind avi_infoframe_builder_core avi_ifb_checker u_avi_ifb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_avi_byte0    (o_avi_byte0),
    .o_avi_byte3    (o_avi_byte3),
    .o_hdmi_vic     (o_hdmi_vic),
    .o_tx_bit_depth (o_tx_bit_depth)
);
